// ===== hdl/zlema_pkg.sv =====
// ----------------------------------------------------------------------------
// zlema_pkg
// Shared widths, constants and types of the zero-lag EMA filter.
// ----------------------------------------------------------------------------
`default_nettype none

package zlema_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 18;
  localparam int unsigned LAG_W    = 6;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned ADDR_W   = 3;

  // alpha after saturation: 0 .. 1.0 in Q1.15
  localparam int unsigned AEFF_W   = ALPHA_W + 1;
  localparam logic [AEFF_W-1:0] ALPHA_ONE = AEFF_W'(32768);
  localparam int unsigned FRAC_W   = 15;

  // difference, product and sum widths of the update
  localparam int unsigned DIFF_W   = OUT_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + AEFF_W + 1;
  localparam int unsigned SUM_W    = 22;

  localparam logic [LAG_W-1:0]   LAG_RESET   = LAG_W'(7);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(4096);

  // register index, taken from paddr[2]
  localparam logic REG_LAG   = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  // request held between the front stage and the output stage
  typedef struct packed {
    logic signed [OUT_W-1:0]    val;   // raw sample when warming, else 2*x[n]-x[n-lag]
    logic signed [SAMPLE_W-1:0] past;  // x[n-lag], seeds the average
    logic                       warm;
    logic                       seed;
  } stage_t;

endpackage

`default_nettype wire

// ===== hdl/zero_lag_ema_filter_top.sv =====
// out_valid rises when the output stage takes its request from the front stage.
// Throughput: one request per cycle unless out_stall holds the output; the average
// recurrence (one subtract, one multiply and one add) is combinational in the output stage.
// Two stages with bubble collapse: one extra request is taken while a result waits.
// Reset (rst, synchronous): lag 7, alpha 4096, warm-up restarted, average 0,
// pipeline empty. The delay cells hold no reset and are read only after fill.
// ----------------------------------------------------------------------------
// zero_lag_ema_filter_top
// Zero-lag EMA over signed 16-bit samples with a chain of delay cells.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_lag_ema_filter_top
  import zlema_pkg::*;
#(
  parameter int unsigned MAX_LAG = 63
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  // output channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [OUT_W-1:0]         filtered,
  output logic                            warming,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_W-1:0]          paddr,
  input  wire logic [APB_W-1:0]           pwdata,
  output logic [APB_W-1:0]                prdata,
  output logic                            pready
);

  localparam int unsigned LAG_CAP = (MAX_LAG > 63) ? 63 : MAX_LAG;
  localparam int unsigned NCELL   = LAG_CAP;

  logic [LAG_W-1:0]   lag;
  logic [ALPHA_W-1:0] alpha;
  logic               cfg_wr;
  logic [LAG_W-1:0]   lag_wr;

  logic [LAG_W-1:0]   fill_count;
  logic               ready;

  logic               accept;
  logic               advance;
  logic               s1_en;
  logic               s1_valid;
  stage_t             s1;
  stage_t             s1_next;

  logic signed [OUT_W-1:0]    prev_avg;
  logic signed [OUT_W-1:0]    ema;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [SAMPLE_W-1:0] chain [NCELL];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign lag_wr = (pwdata[LAG_W-1:0] > LAG_W'(LAG_CAP)) ? LAG_W'(LAG_CAP)
                                                         : pwdata[LAG_W-1:0];

  always_comb begin
    unique case (paddr[2])
      REG_LAG:   prdata = APB_W'(lag);
      REG_ALPHA: prdata = APB_W'(alpha);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag   <= (LAG_RESET > LAG_W'(LAG_CAP)) ? LAG_W'(LAG_CAP) : LAG_RESET;
      alpha <= ALPHA_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LAG:   lag   <= lag_wr;
        REG_ALPHA: alpha <= pwdata[ALPHA_W-1:0];
        default:   ;
      endcase
    end
  end

  // flow control
  assign advance  = !out_valid || !out_stall;
  assign s1_en    = !s1_valid || advance;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;

  // delay chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == NCELL - 1) begin : g_last
      zlema_cell #(.INDEX(i)) u_cell (
        .clk       (clk),
        .shift     (accept),
        .lag       (lag),
        .sample    (sample),
        .from_next (sample),
        .data      (chain[i])
      );
    end else begin : g_mid
      zlema_cell #(.INDEX(i)) u_cell (
        .clk       (clk),
        .shift     (accept),
        .lag       (lag),
        .sample    (sample),
        .from_next (chain[i+1]),
        .data      (chain[i])
      );
    end
  end

  // zero lag: the oldest sample is the current one
  assign past = (lag == '0) ? sample : chain[0];

  always_comb begin
    s1_next.past = past;
    s1_next.warm = !ready;
    s1_next.seed = !ready && (fill_count == lag);
    if (!ready) begin
      s1_next.val = {{(OUT_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    end else begin
      s1_next.val = $signed({sample[SAMPLE_W-1], sample, 1'b0})
                  - $signed({{(OUT_W-SAMPLE_W){past[SAMPLE_W-1]}}, past});
    end
  end

  // warm-up tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ready      <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_LAG) begin
      fill_count <= '0;
      ready      <= 1'b0;
    end else if (accept && !ready) begin
      if (fill_count == lag) begin
        ready <= 1'b1;
      end else begin
        fill_count <= fill_count + LAG_W'(1);
      end
    end
  end

  // front stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  zlema_update u_update (
    .req   (s1),
    .prev  (prev_avg),
    .alpha (alpha),
    .ema   (ema)
  );

  // output stage and average recurrence
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_avg  <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        if (s1.seed) begin
          prev_avg <= {{(OUT_W-SAMPLE_W){s1.past[SAMPLE_W-1]}}, s1.past};
        end else if (!s1.warm) begin
          prev_avg <= ema;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      filtered <= s1.warm ? s1.val : ema;
      warming  <= s1.warm;
    end
  end

  // a lag write restarts warm-up
  assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[2] == REG_LAG) |=> (!ready && fill_count == '0))
    else $error("lag write did not restart warm-up");

  // a request taken before the line is full is marked warming, after it is not
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1.warm == !$past(ready)))
    else $error("warming flag does not follow fill state");

  // a held front request moves out as soon as the output register frees
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("front request not moved to output");

  // a seeding request is always a warming one
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.seed) |-> s1.warm)
    else $error("seed on a filtered request");

endmodule

`default_nettype wire

// ===== hdl/zlema_cell.sv =====
// ----------------------------------------------------------------------------
// zlema_cell
// One delay cell: loads the new sample when it is the tap cell, else the
// neighbor's sample, so a sample leaves cell 0 as past for the request lag requests later.
// ----------------------------------------------------------------------------
`default_nettype none

module zlema_cell
  import zlema_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [LAG_W-1:0]           lag,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic signed [SAMPLE_W-1:0] from_next,
  output logic signed [SAMPLE_W-1:0]      data
);

  logic tap;

  assign tap = (lag == LAG_W'(INDEX + 1));

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= tap ? sample : from_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/zlema_update.sv =====
// ----------------------------------------------------------------------------
// zlema_update
// Average update: prev + floor(alpha * (corrected - prev) / 2^15), saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module zlema_update
  import zlema_pkg::*;
(
  input  wire stage_t                  req,
  input  wire logic signed [OUT_W-1:0] prev,
  input  wire logic [ALPHA_W-1:0]      alpha,
  output logic signed [OUT_W-1:0]      ema
);

  logic [AEFF_W-1:0]        a_eff;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    a_eff = ({1'b0, alpha} > ALPHA_ONE) ? ALPHA_ONE : {1'b0, alpha};
    diff  = $signed({req.val[OUT_W-1], req.val}) - $signed({prev[OUT_W-1], prev});
    prod  = PROD_W'(diff * $signed({1'b0, a_eff}));
    // arithmetic shift floors toward minus infinity
    prod_sh = prod >>> FRAC_W;
    sum   = $signed({{(SUM_W-OUT_W){prev[OUT_W-1]}}, prev}) + $signed(prod_sh[SUM_W-1:0]);
    if (sum[SUM_W-1:OUT_W-1] == '0 || sum[SUM_W-1:OUT_W-1] == '1) begin
      ema = sum[OUT_W-1:0];
    end else if (sum[SUM_W-1]) begin
      ema = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      ema = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_zero_lag_ema_filter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zero_lag_ema_filter_top
// Self-checking bench for the zero-lag EMA filter. A short table of directed
// requests covers warm-up, extremes and register corner cases. It is followed
// by phases of random samples under varied lag/alpha settings and idle
// patterns. Every result is checked against the table or an in-bench model of the filter.
// ----------------------------------------------------------------------------

module tb_zero_lag_ema_filter_top
  import zlema_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS  = 158;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 8;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_LAG, ROW_ALPHA} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [APB_W-1:0]        value;
    logic                    typed;
    logic signed [OUT_W-1:0] filtered;
    logic                    warming;
  } dir_row_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    warming;
  } ema_result_t;

  localparam int unsigned N_DIRECTED = 27;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // warm-up at reset settings: raw pass-through, the eighth request fills
    '{ROW_SAMPLE, 32'h0000_7fff, 1'b1, 18'sh07fff, 1'b1},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b1, 18'sh38000, 1'b1},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 18'sh00000, 1'b1},
    '{ROW_SAMPLE, 32'h0000_ffff, 1'b1, 18'sh3ffff, 1'b1},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 18'sh00001, 1'b1},
    '{ROW_SAMPLE, 32'h0000_5555, 1'b1, 18'sh05555, 1'b1},
    '{ROW_SAMPLE, 32'h0000_aaaa, 1'b1, 18'sh3aaaa, 1'b1},
    '{ROW_SAMPLE, 32'h0000_0064, 1'b1, 18'sh00064, 1'b1},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_7fff, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 18'sh00000, 1'b0},
    // unity weight: output follows the corrected value, widest swings
    '{ROW_ALPHA,  32'h0000_8000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_7fff, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 18'sh00000, 1'b0},
    // lag rewrite restarts warm-up; the filling request seeds the average anew
    '{ROW_LAG,    32'h0000_0000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b1, 18'sh00005, 1'b1},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_7fff, 1'b0, 18'sh00000, 1'b0},
    // zero weight holds the average
    '{ROW_ALPHA,  32'h0000_0000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_1234, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_edcb, 1'b0, 18'sh00000, 1'b0},
    // weight above one saturates
    '{ROW_ALPHA,  32'h0000_ffff, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_fffb, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_7fff, 1'b0, 18'sh00000, 1'b0},
    '{ROW_SAMPLE, 32'h0000_8000, 1'b0, 18'sh00000, 1'b0},
    '{ROW_LAG,    32'h0000_003f, 1'b0, 18'sh00000, 1'b0},
    '{ROW_ALPHA,  32'h0000_1000, 1'b0, 18'sh00000, 1'b0}
  };

  localparam logic [LAG_W-1:0]   PHASE_LAG   [4] = '{6'd63, 6'd0, 6'd1, 6'd31};
  localparam logic [ALPHA_W-1:0] PHASE_ALPHA [5] =
    '{16'd1, 16'd32768, 16'd0, 16'd65535, 16'd4096};

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_W-1:0]    filtered;
  logic                       warming;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [APB_W-1:0]           pwdata;
  logic [APB_W-1:0]           prdata;
  logic                       pready;

  // filter model state
  logic signed [SAMPLE_W-1:0] hist [64];
  int unsigned                hist_wp;
  int unsigned                hist_fill;
  bit                         avg_ready;
  logic signed [OUT_W-1:0]    avg_prev;
  logic [LAG_W-1:0]           cfg_lag;
  logic [ALPHA_W-1:0]         cfg_alpha;

  ema_result_t ema_expected [$];
  ema_result_t head_exp;
  int unsigned fail_count;
  int unsigned cycle_count;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  zero_lag_ema_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .warming   (warming),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // model of one accepted sample
  function automatic void predict_ema(input logic signed [SAMPLE_W-1:0] s,
                                      output ema_result_t res);
    int unsigned depth;
    longint      past;
    longint      diff;
    longint      weight;
    longint      ema;
    depth = cfg_lag + 1;
    hist[hist_wp] = s;
    hist_wp = (hist_wp + 1) % depth;
    if (hist_fill < depth) hist_fill++;
    if (!avg_ready) begin
      if (hist_fill >= depth) begin
        avg_ready = 1'b1;
        avg_prev = hist[hist_wp];
      end
      res.filtered = s;
      res.warming = 1'b1;
    end else begin
      past = hist[hist_wp];
      diff = 2 * longint'(s) - past - longint'(avg_prev);
      weight = (cfg_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cfg_alpha);
      ema = longint'(avg_prev) + ((weight * diff) >>> FRAC_W);
      if (ema > 131071) ema = 131071;
      if (ema < -131072) ema = -131072;
      avg_prev = ema[OUT_W-1:0];
      res.filtered = avg_prev;
      res.warming = 1'b0;
    end
  endfunction

  // present one request, hold it until taken
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v,
                              input ema_result_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    ema_expected.push_back(res);
    in_valid = 1'b1;
    sample = v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_sample(input logic signed [SAMPLE_W-1:0] v);
    ema_result_t res;
    predict_ema(v, res);
    offer_sample(v, res);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (ema_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [APB_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_LAG) begin
      cfg_lag = val[LAG_W-1:0];
      hist_wp = 0;
      hist_fill = 0;
      avg_ready = 1'b0;
    end else begin
      cfg_alpha = val[ALPHA_W-1:0];
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (ema_expected.size() == 0) begin
        $error("result with no request pending: filtered %0d warming %0d",
               filtered, warming);
        fail_count++;
      end else begin
        head_exp = ema_expected.pop_front();
        if (filtered !== head_exp.filtered) begin
          $error("filtered: expected %0d, got %0d", head_exp.filtered, filtered);
          fail_count++;
        end
        if (warming !== head_exp.warming) begin
          $error("warming: expected %0d, got %0d", head_exp.warming, warming);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_zero_lag_ema_filter_top NOT OK");
      $finish;
    end
  end

  initial begin
    ema_result_t             typed_res;
    ema_result_t             res;
    logic [LAG_W-1:0]        lag_pick;
    logic [ALPHA_W-1:0]      alpha_pick;
    logic signed [SAMPLE_W-1:0] v;
    int unsigned             pick;

    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    out_stall = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;

    cfg_lag = LAG_RESET;
    cfg_alpha = ALPHA_RESET;
    hist_wp = 0;
    hist_fill = 0;
    avg_ready = 1'b0;
    avg_prev = '0;
    foreach (hist[k]) hist[k] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_SAMPLE: begin
          predict_ema(DIRECTED[i].value[SAMPLE_W-1:0], res);
          typed_res.filtered = DIRECTED[i].filtered;
          typed_res.warming = DIRECTED[i].warming;
          offer_sample(DIRECTED[i].value[SAMPLE_W-1:0],
                       DIRECTED[i].typed ? typed_res : res);
        end
        ROW_LAG: begin
          drain();
          program_reg(REG_LAG, DIRECTED[i].value);
        end
        default: begin
          drain();
          program_reg(REG_ALPHA, DIRECTED[i].value);
        end
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      lag_pick = (ph < 4) ? PHASE_LAG[ph]
               : ($urandom_range(3) == 0) ? LAG_W'($urandom_range(63))
               : LAG_W'($urandom_range(15));
      alpha_pick = (ph < 5) ? PHASE_ALPHA[ph]
                 : ($urandom_range(7) == 0) ? ALPHA_W'($urandom)
                 : ALPHA_W'($urandom_range(32768, 1));
      program_reg(REG_LAG, APB_W'(lag_pick));
      program_reg(REG_ALPHA, APB_W'(alpha_pick));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 4) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          v = SAMPLE_W'($urandom);
        end else if (pick < 85) begin
          case ($urandom_range(3))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = 16'sh0000;
            default: v = 16'shffff;
          endcase
        end else begin
          v = SAMPLE_W'($urandom_range(200)) - 16'sd100;
        end
        run_sample(v);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && ema_expected.size() == 0) begin
      $display("tb_zero_lag_ema_filter_top OK");
    end else begin
      $display("tb_zero_lag_ema_filter_top NOT OK");
    end
    $finish;
  end

endmodule
